// ===== design/skt_pkg.sv =====
`timescale 1ns / 1ps
package skt_pkg;

    localparam int MAX_KEYS = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int FRAC_W   = 16;

    localparam logic [1:0] REQ_INS = 2'd0;
    localparam logic [1:0] REQ_DEL = 2'd1;
    localparam logic [1:0] REQ_CLR = 2'd2;
    localparam logic [1:0] REQ_LKP = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADIDX = 2'd3;

    localparam logic [2:0] REG_TOL = 3'd0;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [31:0]      key_time;
        logic [IDX_W-1:0] key_index;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  lower_key;
        logic [IDX_W-1:0]  upper_key;
        logic [FRAC_W-1:0] blend_fraction;
        logic              was_created;
        logic [CNT_W-1:0]  key_total;
        logic [31:0]       track_length;
    } t_rsp;

    typedef struct packed {
        logic             cmp_en;
        logic             ins_en;
        logic             del_en;
        logic [IDX_W-1:0] pos;
        logic [31:0]      key_time;
        logic [15:0]      tol;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] sel;
    } t_cell_ctrl;

endpackage

// ===== design/skt_cell.sv =====
`timescale 1ns / 1ps
module skt_cell
    import skt_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  logic [31:0]      i_left,
    input  logic [31:0]      i_right,
    output logic [31:0]      o_time,
    output logic             o_match,
    output logic             o_gt,
    output logic             o_le,
    output logic [31:0]      o_sel_time
);

    logic [31:0] r_time;
    logic        r_match;
    logic        r_gt;
    logic        r_le;
    logic        w_valid;
    logic [31:0] w_diff;

    assign w_valid = {1'b0, i_cell_idx} < i_ctrl.count;
    assign w_diff  = (r_time >= i_ctrl.key_time) ? (r_time - i_ctrl.key_time)
                                                 : (i_ctrl.key_time - r_time);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= w_valid && (w_diff < {16'd0, i_ctrl.tol});
            r_gt    <= w_valid && (r_time > i_ctrl.key_time);
            r_le    <= w_valid && (r_time <= i_ctrl.key_time);
        end
        // insert opens a gap at pos, delete closes the gap at pos
        if (i_ctrl.ins_en) begin
            if (i_cell_idx == i_ctrl.pos) begin
                r_time <= i_ctrl.key_time;
            end else if (i_cell_idx > i_ctrl.pos) begin
                r_time <= i_left;
            end
        end else if (i_ctrl.del_en) begin
            if (i_cell_idx >= i_ctrl.pos) begin
                r_time <= i_right;
            end
        end
    end

    assign o_time     = r_time;
    assign o_match    = r_match;
    assign o_gt       = r_gt;
    assign o_le       = r_le;
    assign o_sel_time = (i_cell_idx == i_ctrl.sel) ? r_time : 32'd0;

endmodule

// ===== design/skt_div.sv =====
`timescale 1ns / 1ps
module skt_div
    import skt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_num,
    input  logic [31:0]       i_den,
    output logic              o_done,
    output logic [FRAC_W-1:0] o_quot
);

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic [31:0]       r_rem;
    logic [31:0]       r_den;
    logic [FRAC_W-1:0] r_quot;
    logic              r_done;
    logic [32:0]       w_sh;
    logic [32:0]       w_sub;

    // remainder stays below the divisor, so one extra bit is enough
    assign w_sh  = {r_rem, 1'b0};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(FRAC_W);
                r_rem  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem  <= w_sub[31:0];
                    r_quot <= {r_quot[FRAC_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_sh[31:0];
                    r_quot <= {r_quot[FRAC_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== design/sorted_keyframe_time_table.sv =====
`timescale 1ns / 1ps
// keyframe time table: ascending list of up to 64 Q16.16 times in a row of cells
// request channel (i_req_valid / o_req_ready, payload i_req) takes insert, delete,
// clear and lookup; every request gives one response on o_rsp_valid / i_rsp_ready
// eq_tolerance is written over the register port at address 0; the user must
// write it only while idle, the block does not enforce this; one request is in
// flight at a time; o_req_ready is high when the block is idle; each request
// passes the compare step, then for insert and lookup a scan that stops at an
// index of up to 64, then for a lookup between two keys two cell reads and the
// 16-step fraction divider, then the response steps; the scan walks the registered
// compare flags of the cells one per cycle; insert and delete shift the cells from
// pos up together; the response sits in an output register; a new request is taken
// while it waits, and a stalled receiver holds the next response in its last step
// reset empties the table and clears the tolerance; entry storage is not cleared
module sorted_keyframe_time_table
    import skt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CMP  = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_RDA  = 4'd3;
    localparam logic [3:0] S_RDB  = 4'd4;
    localparam logic [3:0] S_DST  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_LAST = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]        r_state;
    t_req              r_req;
    logic [15:0]       r_tol;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [1:0]        r_st;
    logic [IDX_W-1:0]  r_lo;
    logic [IDX_W-1:0]  r_up;
    logic [FRAC_W-1:0] r_fr;
    logic              r_cr;
    logic [31:0]       r_a;
    logic [31:0]       r_bus;
    logic              r_out_valid;
    t_rsp              r_rsp;

    t_cell_ctrl        w_ctrl;
    logic [31:0]       w_time   [MAX_KEYS];
    logic [31:0]       w_sel    [MAX_KEYS];
    logic [MAX_KEYS-1:0] w_match;
    logic [MAX_KEYS-1:0] w_gt;
    logic [MAX_KEYS-1:0] w_le;
    logic [31:0]       w_bus;
    logic              w_at_end;
    logic              w_hit;
    logic              w_ins_end;
    logic              w_lkp_end;
    logic              w_full;
    logic              w_div_start;
    logic              w_div_done;
    logic [FRAC_W-1:0] w_quot;
    logic              w_load;

    assign w_at_end  = (r_idx == r_count);
    assign w_hit     = !w_at_end && w_match[r_idx[IDX_W-1:0]];
    assign w_ins_end = w_at_end || w_gt[r_idx[IDX_W-1:0]];
    assign w_lkp_end = w_at_end || !w_le[r_idx[IDX_W-1:0]];
    assign w_full    = (r_count == CNT_W'(MAX_KEYS));
    assign w_load    = (r_state == S_DONE) && (!r_out_valid || i_rsp_ready);
    assign w_div_start = (r_state == S_DST);

    always_comb begin
        w_ctrl          = '0;
        w_ctrl.cmp_en   = (r_state == S_CMP);
        w_ctrl.key_time = r_req.key_time;
        w_ctrl.tol      = r_tol;
        w_ctrl.count    = r_count;
        w_ctrl.pos      = r_idx[IDX_W-1:0];
        w_ctrl.sel      = r_lo;
        unique case (r_state)
            S_CMP: begin
                w_ctrl.pos    = r_req.key_index;
                w_ctrl.del_en = (r_req.req_type == REQ_DEL) &&
                                ({1'b0, r_req.key_index} < r_count);
            end
            S_SCAN: begin
                w_ctrl.ins_en = (r_req.req_type == REQ_INS) && !w_hit && w_ins_end &&
                                !w_full;
            end
            S_RDB:  w_ctrl.sel = r_up;
            // last key stays on the bus while the response waits
            S_LAST: w_ctrl.sel = IDX_W'(r_count - CNT_W'(1));
            S_DONE: w_ctrl.sel = IDX_W'(r_count - CNT_W'(1));
            default: ;
        endcase
    end

    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = 32'd0;
        end else begin : g_mid_l
            assign w_left = w_time[g-1];
        end
        if (g == MAX_KEYS - 1) begin : g_tail
            assign w_right = 32'd0;
        end else begin : g_mid_r
            assign w_right = w_time[g+1];
        end
        skt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_cell_idx (IDX_W'(g)),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_time     (w_time[g]),
            .o_match    (w_match[g]),
            .o_gt       (w_gt[g]),
            .o_le       (w_le[g]),
            .o_sel_time (w_sel[g])
        );
    end

    always_comb begin
        w_bus = 32'd0;
        for (int k = 0; k < MAX_KEYS; k++) begin
            w_bus = w_bus | w_sel[k];
        end
    end

    skt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_req.key_time - r_a),
        .i_den   (r_bus - r_a),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        r_bus <= w_bus;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_tol       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == REG_TOL) begin
                r_tol <= pwdata[15:0];
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_idx   <= '0;
                        r_st    <= ST_OK;
                        r_lo    <= '0;
                        r_up    <= '0;
                        r_fr    <= '0;
                        r_cr    <= 1'b0;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    unique case (r_req.req_type)
                        REQ_DEL: begin
                            if ({1'b0, r_req.key_index} < r_count) begin
                                r_count <= r_count - CNT_W'(1);
                            end else begin
                                r_st <= ST_BADIDX;
                            end
                            r_state <= S_LAST;
                        end
                        REQ_CLR: begin
                            r_count <= '0;
                            r_state <= S_LAST;
                        end
                        REQ_LKP: begin
                            if (r_count == '0) begin
                                r_st    <= ST_EMPTY;
                                r_state <= S_LAST;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        default: r_state <= S_SCAN;
                    endcase
                end
                S_SCAN: begin
                    if (r_req.req_type == REQ_INS) begin
                        priority if (w_hit) begin
                            r_lo    <= r_idx[IDX_W-1:0];
                            r_state <= S_LAST;
                        end else if (w_ins_end) begin
                            if (w_full) begin
                                r_st <= ST_FULL;
                            end else begin
                                r_count <= r_count + CNT_W'(1);
                                r_lo    <= r_idx[IDX_W-1:0];
                                r_cr    <= 1'b1;
                            end
                            r_state <= S_LAST;
                        end else begin
                            r_idx <= r_idx + CNT_W'(1);
                        end
                    end else begin
                        priority if (!w_lkp_end) begin
                            r_idx <= r_idx + CNT_W'(1);
                        end else if (r_idx == '0) begin
                            r_state <= S_LAST;
                        end else if (w_at_end) begin
                            r_lo    <= IDX_W'(r_count - CNT_W'(1));
                            r_up    <= IDX_W'(r_count - CNT_W'(1));
                            r_state <= S_LAST;
                        end else begin
                            // time lies between two keys
                            r_lo    <= IDX_W'(r_idx - CNT_W'(1));
                            r_up    <= r_idx[IDX_W-1:0];
                            r_state <= S_RDA;
                        end
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_a     <= r_bus;
                    r_state <= S_DST;
                end
                S_DST: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_done) begin
                        r_fr    <= w_quot;
                        r_state <= S_LAST;
                    end
                end
                S_LAST: r_state <= S_DONE;
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (w_load) begin
            r_rsp.status         <= r_st;
            r_rsp.lower_key      <= r_lo;
            r_rsp.upper_key      <= r_up;
            r_rsp.blend_fraction <= r_fr;
            r_rsp.was_created    <= r_cr;
            r_rsp.key_total      <= r_count;
            r_rsp.track_length   <= (r_count != '0) ? r_bus : 32'd0;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;
    assign pready      = 1'b1;
    assign prdata      = (paddr == REG_TOL) ? {16'd0, r_tol} : 32'd0;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEYS))
        else $error("key count above table size");

    a_created_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.was_created |-> o_rsp.key_total != '0)
        else $error("created key but table empty");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide step");

endmodule

// ===== tb/sorted_keyframe_time_table_tb.sv =====
`timescale 1ns / 1ps
module sorted_keyframe_time_table_tb
    import skt_pkg::*;
();

    localparam int WATCHDOG_CYCLES = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_ready;
    t_req        i_req;
    logic        o_rsp_valid;
    logic        i_rsp_ready;
    t_rsp        o_rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sorted_keyframe_time_table u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_ready(o_req_ready), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_ready(i_rsp_ready), .o_rsp(o_rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [31:0] table_times [MAX_KEYS];
    int unsigned table_count;
    logic [15:0] tol_setting;

    t_rsp rsp_pending [$];
    int   mismatch_count;
    int   idle_cycles;
    bit   rsp_stall_on;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic t_rsp predict_table_op(t_req rq);
        t_rsp        rs;
        int unsigned pos;
        int unsigned i;
        logic [31:0] v;
        logic [31:0] d;
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] q;
        bit          found;
        rs = '0;
        rs.status = ST_OK;
        found = 0;
        case (rq.req_type)
            REQ_INS: begin
                pos = table_count;
                for (i = 0; i < table_count; i++) begin
                    v = table_times[i];
                    d = (v >= rq.key_time) ? v - rq.key_time : rq.key_time - v;
                    if (d < {16'd0, tol_setting}) begin
                        rs.lower_key = i[5:0];
                        found = 1;
                        break;
                    end
                    if (v > rq.key_time) begin
                        pos = i;
                        break;
                    end
                end
                if (!found) begin
                    if (table_count >= MAX_KEYS) begin
                        rs.status = ST_FULL;
                    end else begin
                        for (i = table_count; i > pos; i--)
                            table_times[i] = table_times[i-1];
                        table_times[pos] = rq.key_time;
                        table_count++;
                        rs.lower_key = pos[5:0];
                        rs.was_created = 1'b1;
                    end
                end
            end
            REQ_DEL: begin
                if (rq.key_index >= table_count) begin
                    rs.status = ST_BADIDX;
                end else begin
                    for (i = rq.key_index; i + 1 < table_count; i++)
                        table_times[i] = table_times[i+1];
                    table_count--;
                end
            end
            REQ_CLR: table_count = 0;
            default: begin
                if (table_count == 0) begin
                    rs.status = ST_EMPTY;
                end else begin
                    i = 0;
                    while (i < table_count && table_times[i] <= rq.key_time) i++;
                    if (i == table_count) begin
                        rs.lower_key = 6'(table_count - 1);
                        rs.upper_key = 6'(table_count - 1);
                    end else if (i != 0) begin
                        a = table_times[i-1];
                        b = table_times[i];
                        rs.lower_key = 6'(i - 1);
                        rs.upper_key = 6'(i);
                        if (b != a) begin
                            q = {16'd0, rq.key_time - a, 16'd0} / {32'd0, b - a};
                            rs.blend_fraction = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
                        end
                    end
                end
            end
        endcase
        rs.key_total = 7'(table_count);
        rs.track_length = (table_count > 0) ? table_times[table_count-1] : 32'd0;
        return rs;
    endfunction

    task automatic send_request(logic [1:0] kind, logic [31:0] t, logic [5:0] idx);
        t_req rq;
        int unsigned g;
        g = gap_len();
        // valid drops between requests for a random gap
        repeat (g + 1) @(negedge i_clk);
        rq.req_type = kind;
        rq.key_time = t;
        rq.key_index = idx;
        i_req <= rq;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        rsp_pending = {rsp_pending, predict_table_op(rq)};
        @(negedge i_clk);
        i_req_valid <= 1'b0;
    endtask

    task automatic drain_responses();
        while (rsp_pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_tolerance(logic [15:0] val);
        drain_responses();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_TOL; pwdata <= {16'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        tol_setting = val;
    endtask

    // random time, often near existing keys so matches and brackets are exercised
    function automatic logic [31:0] pick_time();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (table_count != 0 && r < 6)
            return table_times[$urandom_range(0, table_count-1)]
                   + 32'($urandom_range(0, 600)) - 32'd300;
        if (r < 8) return 32'($urandom_range(0, 32'h000F_FFFF));
        return $urandom();
    endfunction

    task automatic test_directed();
        send_request(REQ_LKP, 32'h1234_0000, 6'd0);
        send_request(REQ_DEL, 32'd0, 6'd0);
        send_request(REQ_INS, 32'd0, 6'd63);
        send_request(REQ_INS, 32'hFFFF_FFFF, 6'd0);
        send_request(REQ_INS, 32'h0001_0000, 6'd0);
        send_request(REQ_INS, 32'h0001_0000, 6'd0);
        send_request(REQ_LKP, 32'h0000_8000, 6'd0);
        send_request(REQ_LKP, 32'h0001_0000, 6'd0);
        send_request(REQ_LKP, 32'hFFFF_FFFF, 6'd0);
        send_request(REQ_LKP, 32'hAAAA_5555, 6'd0);
        send_request(REQ_DEL, 32'd0, 6'd63);
        send_request(REQ_DEL, 32'd0, 6'd1);
        send_request(REQ_CLR, 32'd0, 6'd0);
        send_request(REQ_LKP, 32'd0, 6'd0);
        send_request(REQ_INS, 32'h0000_0100, 6'd0);
        send_request(REQ_LKP, 32'h0000_0000, 6'd0);
    endtask

    task automatic test_tolerance_match();
        write_tolerance(16'hFFFF);
        send_request(REQ_INS, 32'h0000_FF00, 6'd0);
        send_request(REQ_INS, 32'h0002_0000, 6'd0);
        send_request(REQ_INS, 32'h0001_0100, 6'd0);
        send_request(REQ_LKP, 32'h0001_8000, 6'd0);
        write_tolerance(16'd1);
        send_request(REQ_INS, 32'h0002_0000, 6'd0);
        send_request(REQ_INS, 32'h0002_0001, 6'd0);
    endtask

    task automatic test_full_table();
        int k;
        write_tolerance(16'd0);
        send_request(REQ_CLR, 32'd0, 6'd0);
        for (k = 0; k < MAX_KEYS + 2; k++)
            send_request(REQ_INS, $urandom(), 6'($urandom()));
        send_request(REQ_INS, 32'h0000_0000, 6'd0);
        send_request(REQ_LKP, $urandom(), 6'd0);
        send_request(REQ_DEL, 32'd0, 6'd63);
        send_request(REQ_DEL, 32'd0, 6'd0);
    endtask

    task automatic test_random_ops(int n);
        int k;
        int unsigned r;
        logic [5:0] idx;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_request(REQ_INS, pick_time(), 6'($urandom()));
            end else if (r < 55) begin
                idx = (table_count != 0 && r < 52) ? 6'($urandom_range(0, table_count-1))
                                                   : 6'($urandom());
                send_request(REQ_DEL, $urandom(), idx);
            end else if (r < 57) begin
                send_request(REQ_CLR, $urandom(), 6'($urandom()));
            end else begin
                send_request(REQ_LKP, pick_time(), 6'($urandom()));
            end
        end
    endtask

    // response side: random stalls while rsp_stall_on is set, then compare against oldest prediction
    initial begin
        int unsigned g;
        i_rsp_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_stall_on) begin
                g = gap_len();
                if (g != 0) begin
                    i_rsp_ready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
            end
            i_rsp_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (rsp_pending.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response %p", o_rsp);
            end else begin
                exp_rsp = rsp_pending.pop_front();
                if (o_rsp.status !== exp_rsp.status
                    || o_rsp.lower_key !== exp_rsp.lower_key
                    || o_rsp.upper_key !== exp_rsp.upper_key
                    || o_rsp.blend_fraction !== exp_rsp.blend_fraction
                    || o_rsp.was_created !== exp_rsp.was_created
                    || o_rsp.key_total !== exp_rsp.key_total
                    || o_rsp.track_length !== exp_rsp.track_length) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("response mismatch: expected %p actual %p",
                                 exp_rsp, o_rsp);
                end
            end
        end
    end

    // watchdog on handshake inactivity
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("sorted_keyframe_time_table verification failed");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        idle_cycles = 0;
        rsp_stall_on = 1;
        table_count = 0;
        tol_setting = 16'd0;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_tolerance_match();
        test_full_table();
        write_tolerance(16'd200);
        test_random_ops(350);
        rsp_stall_on = 0;
        test_random_ops(100);
        rsp_stall_on = 1;
        write_tolerance(16'd0);
        test_random_ops(300);
        write_tolerance(16'h0400);
        test_random_ops(100);
        drain_responses();
        if (mismatch_count == 0)
            $display("sorted_keyframe_time_table verification clean");
        else
            $display("sorted_keyframe_time_table verification failed");
        $finish;
    end

endmodule

// ===== sorted_keyframe_time_table.f =====
design/skt_pkg.sv
design/skt_cell.sv
design/skt_div.sv
design/sorted_keyframe_time_table.sv
tb/sorted_keyframe_time_table_tb.sv
